// File: rtl/kmcr_pkg.sv
`timescale 1ns / 1ps
package kmcr_pkg;

  localparam int ROWS = 6;
  localparam int COLS = 4;

  localparam int COL_W = 2;
  localparam int ROW_W = 6;
  localparam int KEY_W = 5;

  localparam int TABLE_ROWS = 6;
  localparam int TABLE_COLS = 4;

  localparam int ROWS_USED = (ROWS < ROW_W) ? ROWS : ROW_W;
  localparam logic [ROW_W-1:0] ROW_MASK = ROW_W'((64'd1 << ROWS_USED) - 64'd1);
  localparam int ROW_IDX_W = $clog2(ROW_W);
  localparam int COL_IDX_W = (COLS > 1) ? $clog2(COLS) : 1;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] id;
  } slot_t;

  localparam slot_t KEY_TABLE [TABLE_ROWS][TABLE_COLS] = '{
    '{'{1'b0, 5'd0},  '{1'b0, 5'd0},  '{1'b0, 5'd0},  '{1'b1, 5'd0}},
    '{'{1'b1, 5'd1},  '{1'b1, 5'd2},  '{1'b1, 5'd3},  '{1'b1, 5'd4}},
    '{'{1'b1, 5'd5},  '{1'b1, 5'd6},  '{1'b1, 5'd7},  '{1'b0, 5'd0}},
    '{'{1'b1, 5'd8},  '{1'b1, 5'd9},  '{1'b1, 5'd10}, '{1'b1, 5'd11}},
    '{'{1'b1, 5'd12}, '{1'b1, 5'd13}, '{1'b1, 5'd14}, '{1'b0, 5'd0}},
    '{'{1'b1, 5'd15}, '{1'b1, 5'd16}, '{1'b0, 5'd0},  '{1'b1, 5'd17}}
  };

  // positions outside the table are unused
  function automatic slot_t key_lookup(input int row, input int col);
    slot_t s;
    s = '0;
    if (row < TABLE_ROWS && col < TABLE_COLS) begin
      s = KEY_TABLE[row][col];
    end
    return s;
  endfunction

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic pend_empty;
    logic pend_one;
  } dp_status_t;

endpackage

// File: rtl/kmcr_scan_if.sv
`timescale 1ns / 1ps
interface kmcr_scan_if
  import kmcr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row_sample;

  modport source (output valid, output column, output row_sample, input ready);
  modport sink (input valid, input column, input row_sample, output ready);
endinterface

// File: rtl/kmcr_report_if.sv
`timescale 1ns / 1ps
interface kmcr_report_if
  import kmcr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_id;
  logic             pressed;
  logic             last_event;

  modport source (output valid, output key_id, output pressed, output last_event, input ready);
  modport sink (input valid, input key_id, input pressed, input last_event, output ready);
endinterface

// File: rtl/key_matrix_change_reporter.sv
`timescale 1ns / 1ps
// The scan transaction loads the pending-row store, and the first event of a
// column is then registered in the output register. Throughput: one event per
// cycle while report.ready is high, through the single-event output register;
// a column gives at most five events. The next column is taken on the last event.
// Reset (rst, synchronous): previous-row store cleared, no event pending.
module key_matrix_change_reporter
  import kmcr_pkg::*;
(
  input logic         clk,
  input logic         rst,
  kmcr_scan_if.sink   scan,
  kmcr_report_if.source report
);

  dp_cmd_t    cmd;
  dp_status_t status;

  kmcr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .scan_valid   (scan.valid),
    .scan_ready   (scan.ready),
    .report_valid (report.valid),
    .report_ready (report.ready),
    .status       (status),
    .cmd          (cmd)
  );

  kmcr_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .column     (scan.column),
    .row_sample (scan.row_sample),
    .key_id     (report.key_id),
    .pressed    (report.pressed),
    .last_event (report.last_event)
  );

endmodule

// File: rtl/kmcr_datapath.sv
`timescale 1ns / 1ps
module kmcr_datapath
  import kmcr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  output dp_status_t       status,
  input  logic [COL_W-1:0] column,
  input  logic [ROW_W-1:0] row_sample,
  output logic [KEY_W-1:0] key_id,
  output logic             pressed,
  output logic             last_event
);

  logic [ROW_W-1:0]     prev_rows [COLS];
  logic [ROW_W-1:0]     pending;
  logic [ROW_W-1:0]     now_bits;
  logic [COL_W-1:0]     cur_col;

  logic [ROW_W-1:0]     now_in;
  logic [ROW_W-1:0]     used_mask;
  logic [ROW_W-1:0]     changed;
  logic                 col_ok;
  logic [COL_IDX_W-1:0] col_idx;
  logic [ROW_IDX_W-1:0] sel;
  slot_t                sel_slot;

  assign col_ok  = 32'(column) < COLS;
  assign col_idx = COL_IDX_W'(column);
  assign now_in  = row_sample & ROW_MASK;
  assign changed = (prev_rows[col_idx] ^ now_in) & ROW_MASK;

  always_comb begin
    for (int r = 0; r < ROW_W; r++) begin
      used_mask[r] = key_lookup(r, int'(column)).used;
    end
  end

  // lowest pending row
  always_comb begin
    sel = '0;
    for (int r = ROW_W - 1; r >= 0; r--) begin
      if (pending[r]) begin
        sel = ROW_IDX_W'(r);
      end
    end
  end

  assign sel_slot = key_lookup(int'(sel), int'(cur_col));

  assign status.pend_empty = (pending == '0);
  assign status.pend_one   = (pending != '0) && ((pending & (pending - 1'b1)) == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < COLS; c++) begin
        prev_rows[c] <= '0;
      end
      pending <= '0;
    end else if (cmd.load) begin
      if (col_ok) begin
        prev_rows[col_idx] <= now_in;
        pending            <= changed & used_mask;
      end else begin
        pending <= '0;
      end
    end else if (cmd.step) begin
      pending[sel] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_bits <= now_in;
      cur_col  <= column;
    end
    if (cmd.step) begin
      key_id     <= sel_slot.id;
      pressed    <= now_bits[sel];
      last_event <= status.pend_one;
    end
  end

endmodule

// File: rtl/kmcr_ctrl.sv
`timescale 1ns / 1ps
module kmcr_ctrl
  import kmcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       scan_valid,
  output logic       scan_ready,
  output logic       report_valid,
  input  logic       report_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic {IDLE, EMIT} state_t;

  state_t state;
  logic   advance;
  logic   finishing;

  assign advance    = (state == EMIT) && !status.pend_empty && (!report_valid || report_ready);
  assign finishing  = (state == EMIT) && (status.pend_empty || (advance && status.pend_one));
  assign scan_ready = (state == IDLE) || finishing;
  assign cmd.load   = scan_valid && scan_ready;
  assign cmd.step   = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      report_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        state <= EMIT;
      end else if (finishing) begin
        state <= IDLE;
      end
      if (advance) begin
        report_valid <= 1'b1;
      end else if (report_ready) begin
        report_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/kmcr_checker.sv
`timescale 1ns / 1ps
module kmcr_checker
  import kmcr_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             scan_ready,
  input logic             report_valid,
  input logic             report_ready,
  input logic [KEY_W-1:0] key_id,
  input logic             pressed,
  input logic             last_event
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !report_valid)
    else $error("event valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report_ready |=>
      report_valid && $stable(key_id) && $stable(pressed) && $stable(last_event))
    else $error("stalled event changed");

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> key_id <= KEY_W'(17))
    else $error("key id out of range");

  a_no_early_take: assert property (@(posedge clk) disable iff (rst)
    report_valid && !last_event && !report_ready |-> !scan_ready)
    else $error("new column taken while events remain");

endmodule

bind key_matrix_change_reporter kmcr_checker u_kmcr_checker (
  .clk          (clk),
  .rst          (rst),
  .scan_ready   (scan.ready),
  .report_valid (report.valid),
  .report_ready (report.ready),
  .key_id       (report.key_id),
  .pressed      (report.pressed),
  .last_event   (report.last_event)
);
